// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each one checks on the rising edge of clk
// and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The expression must hold in every cycle.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// ----- sv/rfad_pkg.sv -----
package rfad_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR1,
    PH_LOW,
    PH_HIGH
  } phase_t;

  localparam int APB_ADDR_W = 3;
  localparam int LINE_DEPTH_DEF = 4;

  localparam logic REG_HEADER = 1'b0;

  localparam logic [7:0] HEADER_RESET = 8'h59;
  localparam logic [13:0] DIST_MAX = 14'd9999;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_NL = 8'h0a;

  localparam logic [2:0] POS_C = 3'd4;
  localparam logic [2:0] POS_M = 3'd5;
  localparam logic [2:0] POS_NL = 3'd6;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic valid;
    logic [13:0] dist_val;
  } dist_t;

  // dig[0] holds the thousands and dig[3] the units.
  typedef struct packed {
    digit_t [3:0] dig;
    logic [1:0] start;
  } line_t;

  // Splits a value below 100 into its tens and units digits.
  function automatic logic [7:0] split_tens(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0] t;
    logic [6:0] o;
    p = 18'(v) * 18'd205;
    t = p[14:11];
    o = v - 7'(t) * 7'd10;
    return {t, o[3:0]};
  endfunction

endpackage

// ----- sv/rfad_frame.sv -----
module rfad_frame
  import rfad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       accept,
  input  logic [7:0] header_value,
  output logic       high_byte,
  output dist_t      dist_out
);

  phase_t phase;
  phase_t phase_next;
  logic [7:0] distance_low;
  logic [15:0] full;
  logic [13:0] sat;
  logic dist_valid;
  logic [13:0] dist_value;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT: phase_next = (rx_byte == header_value) ? PH_HDR1 : PH_HUNT;
        PH_HDR1: phase_next = (rx_byte == header_value) ? PH_LOW : PH_HUNT;
        PH_LOW:  phase_next = PH_HIGH;
        PH_HIGH: phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    high_byte = (phase == PH_HIGH);
    full = {rx_byte, distance_low};
    sat = (full > 16'(DIST_MAX)) ? DIST_MAX : full[13:0];
  end

  assign dist_out = {dist_valid, dist_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      distance_low <= '0;
      dist_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept && phase == PH_LOW) begin
        distance_low <= rx_byte;
      end
      dist_valid <= accept && high_byte;
    end
  end

  always_ff @(posedge clk) begin
    dist_value <= sat;
  end

endmodule

// ----- sv/rfad_digits.sv -----
module rfad_digits
  import rfad_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  dist_t dist_in,
  output logic  line_valid,
  output line_t line_out
);

  logic        v1;
  logic [13:0] d1;
  logic [6:0]  q1;
  logic [1:0]  start1;
  logic [26:0] prod;
  logic [1:0]  start_calc;
  logic [13:0] diff;
  logic [7:0]  hi_pair;
  logic [7:0]  lo_pair;

  always_comb begin
    prod = 27'(dist_in.dist_val) * 27'd5243;
    if (dist_in.dist_val >= 14'd1000) begin
      start_calc = 2'd0;
    end else if (dist_in.dist_val >= 14'd100) begin
      start_calc = 2'd1;
    end else if (dist_in.dist_val >= 14'd10) begin
      start_calc = 2'd2;
    end else begin
      start_calc = 2'd3;
    end
  end

  always_comb begin
    diff = d1 - 14'(q1) * 14'd100;
    hi_pair = split_tens(q1);
    lo_pair = split_tens(diff[6:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      v1 <= dist_in.valid;
      line_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    d1 <= dist_in.dist_val;
    q1 <= prod[25:19];
    start1 <= start_calc;
    line_out.dig[0] <= hi_pair[7:4];
    line_out.dig[1] <= hi_pair[3:0];
    line_out.dig[2] <= lo_pair[7:4];
    line_out.dig[3] <= lo_pair[3:0];
    line_out.start <= start1;
  end

endmodule

// ----- sv/rfad_line_fifo.sv -----
module rfad_line_fifo
  import rfad_pkg::*;
#(
  parameter int DEPTH = LINE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  line_t wr_data,
  input  logic  rd_en,
  output line_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  line_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rfad_serial.sv -----
module rfad_serial
  import rfad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  line_t      head,
  input  logic       empty,
  input  logic       tx_stall,
  output logic       pop,
  output logic [7:0] tx_char,
  output logic       last_char,
  output logic       tx_valid
);

  logic [2:0] pos;
  logic       started;
  logic [2:0] cur;
  logic       load;
  logic       emit;
  logic [7:0] ch;

  always_comb begin
    load = !tx_valid || !tx_stall;
    emit = load && !empty;
    cur = started ? pos : {1'b0, head.start};
    pop = emit && (cur == POS_NL);
    case (cur)
      POS_C:   ch = CH_C;
      POS_M:   ch = CH_M;
      POS_NL:  ch = CH_NL;
      default: ch = CH_ZERO + {4'b0000, head.dig[cur[1:0]]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      started <= 1'b0;
      pos <= '0;
    end else begin
      if (load) begin
        tx_valid <= emit;
      end
      if (pop) begin
        started <= 1'b0;
      end else if (emit) begin
        started <= 1'b1;
        pos <= cur + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_char <= ch;
      last_char <= (cur == POS_NL);
    end
  end

endmodule

// ----- sv/range_frame_to_ascii_decimal.sv -----
// Received bytes enter on the rx channel, one word per cycle while rx_stall is low. A frame is two
// header bytes equal to the header register (matched sliding), a low and a high distance byte; the high
// byte yields one text line, the distance saturated to 9999 in decimal without leading zeros, then "cm"
// and a newline, with last_char set on the newline. A line passes the frame's distance register and the
// registers of the digit stage before it is written to the line queue. The output side sends one character
// a cycle while tx_stall is low, and a line of n digits has n + 3 characters, at most 7; the line queue
// of LINE_DEPTH lines absorbs the difference, and rx_stall rises only when every queue slot is spoken
// for by lines queued or still being converted.
`include "assert_macros.svh"

module range_frame_to_ascii_decimal
  import rfad_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic [7:0]            rx_byte,
  input  logic                  rx_valid,
  output logic                  rx_stall,
  output logic [7:0]            tx_char,
  output logic                  last_char,
  output logic                  tx_valid,
  input  logic                  tx_stall
);

  localparam int PEND_W = $clog2(LINE_DEPTH + 1);

  logic [7:0]        header_value;
  logic [PEND_W-1:0] pending;
  logic              rx_accept;
  logic              high_byte;
  dist_t             dist_word;
  logic              line_valid;
  line_t             line;
  line_t             head;
  logic              empty;
  logic              pop;
  logic              inc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, header_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER) begin
      header_value <= pwdata[7:0];
    end
  end

  assign rx_stall = (pending == PEND_W'(LINE_DEPTH));
  assign rx_accept = rx_valid && !rx_stall;
  assign inc = rx_accept && high_byte;

  // Counts lines in conversion and in the queue, so no line can find the queue full.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (inc && !pop) begin
      pending <= pending + 1'b1;
    end else if (pop && !inc) begin
      pending <= pending - 1'b1;
    end
  end

  rfad_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .accept       (rx_accept),
    .header_value (header_value),
    .high_byte    (high_byte),
    .dist_out     (dist_word)
  );

  rfad_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .dist_in    (dist_word),
    .line_valid (line_valid),
    .line_out   (line)
  );

  rfad_line_fifo #(
    .DEPTH (LINE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (line_valid),
    .wr_data (line),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  rfad_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .tx_stall  (tx_stall),
    .pop       (pop),
    .tx_char   (tx_char),
    .last_char (last_char),
    .tx_valid  (tx_valid)
  );

  `ASSERT_ALWAYS(a_pending_bound, pending <= PEND_W'(LINE_DEPTH), "line count above depth")
  `ASSERT_IMPLIES(a_pop_pending, pop, pending != '0, "line sent that was never counted")
  `ASSERT_IMPLIES(a_last_is_nl, tx_valid && last_char, tx_char == CH_NL, "last word not newline")

endmodule
